[design/voxel_line_traversal_defines.svh]
// Assertion helpers for the asserting file, voxel_line_traversal.sv.
`ifndef VOXEL_LINE_TRAVERSAL_DEFINES_SVH
`define VOXEL_LINE_TRAVERSAL_DEFINES_SVH

`define VLT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define VLT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/vlt_pkg.sv]
package vlt_pkg;

    localparam int COORD_W     = 32;
    localparam int SIZE_W      = 24;
    localparam int DELTA_W     = COORD_W + 1;
    localparam int DEN_W       = 33;
    localparam int NUM_W       = 35;
    localparam int CHUNK_W     = 11;
    localparam int NCHUNK      = DEN_W / CHUNK_W;
    localparam int CHUNK_IDX_W = 2;
    localparam int PP_W        = NUM_W + CHUNK_W;
    localparam int PROD_W      = NUM_W + DEN_W;
    localparam int DIV_STEPS   = COORD_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int AXIS_W      = 2;
    localparam int MAX_CELLS_DEF = 64;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam logic [1:0] REG_CELL_SIZE_X = 2'd0;
    localparam logic [1:0] REG_CELL_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_CELL_SIZE_Z = 2'd2;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_z;
    } seg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] cell_x;
        logic signed [COORD_W-1:0] cell_y;
        logic signed [COORD_W-1:0] cell_z;
        logic                      last_cell;
        logic                      truncated;
    } voxel_t;

    typedef struct packed {
        logic                   load;
        logic                   div_step;
        logic                   init;
        logic                   best_clear;
        logic                   best_take;
        logic                   mul_clear;
        logic                   mul_step;
        logic                   best_upd;
        logic                   emit;
        logic                   advance;
        logic [AXIS_W-1:0]      axis;
        logic [CHUNK_IDX_W-1:0] chunk;
        logic                   last;
        logic                   trunc;
    } cmd_t;

    typedef struct packed {
        logic same;
        logic active;
        logic best_valid;
        logic beyond;
        logic less;
        logic out_free;
    } stat_t;

endpackage

[design/voxel_line_traversal.sv]
// Channel   Direction  Handshake                 Payload
// seg       in         seg_valid / seg_stall     vlt_pkg::seg_t, one segment request
// voxel     out        voxel_valid / voxel_stall vlt_pkg::voxel_t, one visited cell
// apb       in/out     psel, penable, pready     cell sizes at byte addresses 0, 4, 8
//
// A segment is set up by the six parallel floor dividers and then walked cell by cell, each
// step set by the chunked cross-multiply compare of axes.
// A segment whose ends share a cell yields its single cell once the divide and init steps end.
// Reset clears the controller and the output valid flag; cell sizes reset to 1.
// The block takes one segment at a time; a stalled result holds the walk.
`include "voxel_line_traversal_defines.svh"

module voxel_line_traversal #(
    parameter int MAX_CELLS = vlt_pkg::MAX_CELLS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         seg_valid,
    output logic                         seg_stall,
    input  vlt_pkg::seg_t                seg,
    output logic                         voxel_valid,
    input  logic                         voxel_stall,
    output vlt_pkg::voxel_t              voxel,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [vlt_pkg::PADDR_W-1:0]  paddr,
    input  logic [vlt_pkg::PDATA_W-1:0]  pwdata,
    output logic [vlt_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    logic [2:0][vlt_pkg::SIZE_W-1:0] size_reg;
    logic [2:0][vlt_pkg::SIZE_W-1:0] size_eff;
    logic [1:0]                      reg_idx;
    vlt_pkg::cmd_t                   cmd;
    vlt_pkg::stat_t                  stat;
    logic                            busy;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= {3{vlt_pkg::SIZE_W'(1)}};
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                vlt_pkg::REG_CELL_SIZE_X: size_reg[0] <= pwdata[vlt_pkg::SIZE_W-1:0];
                vlt_pkg::REG_CELL_SIZE_Y: size_reg[1] <= pwdata[vlt_pkg::SIZE_W-1:0];
                vlt_pkg::REG_CELL_SIZE_Z: size_reg[2] <= pwdata[vlt_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            size_eff[k] = (size_reg[k] == '0) ? vlt_pkg::SIZE_W'(1) : size_reg[k];
        unique case (reg_idx)
            vlt_pkg::REG_CELL_SIZE_X: prdata = vlt_pkg::PDATA_W'(size_reg[0]);
            vlt_pkg::REG_CELL_SIZE_Y: prdata = vlt_pkg::PDATA_W'(size_reg[1]);
            vlt_pkg::REG_CELL_SIZE_Z: prdata = vlt_pkg::PDATA_W'(size_reg[2]);
            default:                  prdata = '0;
        endcase
    end

    assign seg_stall = busy;

    vlt_ctrl #(
        .MAX_CELLS (MAX_CELLS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy)
    );

    vlt_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .seg         (seg),
        .size        (size_eff),
        .cmd         (cmd),
        .stat        (stat),
        .voxel_stall (voxel_stall),
        .voxel_valid (voxel_valid),
        .voxel       (voxel)
    );

    `VLT_ASSERT_NEXT(a_busy_after_accept, seg_valid && !seg_stall, seg_stall, "idle after accept")
    `VLT_ASSERT_IMP(a_trunc_is_last, voxel_valid && voxel.truncated, voxel.last_cell, "inner trunc")
    `VLT_ASSERT_IMP(a_walk_goes_on, voxel_valid && !voxel.last_cell, seg_stall, "walk ended early")

endmodule

[design/vlt_ctrl.sv]
module vlt_ctrl #(
    parameter int MAX_CELLS = vlt_pkg::MAX_CELLS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            seg_valid,
    input  vlt_pkg::stat_t  stat,
    output vlt_pkg::cmd_t   cmd,
    output logic            busy
);

    localparam int CNT_W = $clog2(MAX_CELLS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV    = 3'd1;
    localparam logic [2:0] S_INIT   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_CMP    = 3'd5;
    localparam logic [2:0] S_DECIDE = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    logic [2:0]                        state_reg, state_next;
    logic [vlt_pkg::DIV_CNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic [vlt_pkg::AXIS_W-1:0]        axis_reg, axis_next;
    logic [vlt_pkg::CHUNK_IDX_W-1:0]   chunk_reg, chunk_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic                              last_reg, last_next;
    logic                              trunc_reg, trunc_next;
    logic                              at_limit;

    assign at_limit = ((CNT_W+1)'(count_reg) + (CNT_W+1)'(1)) >= (CNT_W+1)'(MAX_CELLS);
    assign busy     = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
            axis_reg    <= '0;
            chunk_reg   <= '0;
            count_reg   <= '0;
            last_reg    <= 1'b0;
            trunc_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            axis_reg    <= axis_next;
            chunk_reg   <= chunk_next;
            count_reg   <= count_next;
            last_reg    <= last_next;
            trunc_reg   <= trunc_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        axis_next    = axis_reg;
        chunk_next   = chunk_reg;
        count_next   = count_reg;
        last_next    = last_reg;
        trunc_next   = trunc_reg;
        cmd          = '0;
        cmd.axis     = axis_reg;
        cmd.chunk    = chunk_reg;
        cmd.last     = last_reg;
        cmd.trunc    = trunc_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (seg_valid)
                begin
                    cmd.load     = 1'b1;
                    div_cnt_next = '0;
                    count_next   = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == vlt_pkg::DIV_CNT_W'(vlt_pkg::DIV_STEPS - 1))
                    state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.init       = 1'b1;
                cmd.best_clear = 1'b1;
                axis_next      = vlt_pkg::AXIS_X;
                if (stat.same)
                begin
                    last_next  = 1'b1;
                    trunc_next = 1'b0;
                    state_next = S_EMIT;
                end
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.active && stat.best_valid)
                begin
                    cmd.mul_clear = 1'b1;
                    chunk_next    = '0;
                    state_next    = S_MUL;
                end
                else
                begin
                    cmd.best_take = stat.active;
                    if (axis_reg == vlt_pkg::AXIS_Z)
                        state_next = S_DECIDE;
                    else
                        axis_next = axis_reg + 1'b1;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                chunk_next   = chunk_reg + 1'b1;
                if (chunk_reg == vlt_pkg::CHUNK_IDX_W'(vlt_pkg::NCHUNK - 1))
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.best_upd = 1'b1;
                if (axis_reg == vlt_pkg::AXIS_Z)
                    state_next = S_DECIDE;
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_DECIDE:
            begin
                last_next  = stat.beyond || at_limit;
                trunc_next = !stat.beyond && at_limit;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (last_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        cmd.advance    = 1'b1;
                        cmd.best_clear = 1'b1;
                        count_next     = count_reg + 1'b1;
                        axis_next      = vlt_pkg::AXIS_X;
                        state_next     = S_SCAN;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

[design/vlt_datapath.sv]
module vlt_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  vlt_pkg::seg_t                       seg,
    input  logic [2:0][vlt_pkg::SIZE_W-1:0]     size,
    input  vlt_pkg::cmd_t                       cmd,
    output vlt_pkg::stat_t                      stat,
    input  logic                                voxel_stall,
    output logic                                voxel_valid,
    output vlt_pkg::voxel_t                     voxel
);

    localparam int CW = vlt_pkg::COORD_W;
    localparam int SW = vlt_pkg::SIZE_W;

    logic signed [CW-1:0]            lane_in [0:5];
    logic [CW-1:0]                   dq_reg [0:5];
    logic [SW-1:0]                   rem_reg [0:5];
    logic                            neg_reg [0:5];
    logic [CW-1:0]                   fq [0:5];
    logic [SW-1:0]                   fr [0:5];
    logic [SW:0]                     trial [0:5];
    logic                            fit [0:5];

    logic signed [CW-1:0]            s_reg [0:2];
    logic signed [CW-1:0]            e_reg [0:2];
    logic signed [CW-1:0]            cur_reg [0:2];
    logic [vlt_pkg::NUM_W-1:0]       num_reg [0:2];
    logic [vlt_pkg::DEN_W-1:0]       den_reg [0:2];
    logic                            dneg_reg [0:2];
    logic                            nz_reg [0:2];
    logic signed [vlt_pkg::DELTA_W-1:0] dlt [0:2];

    logic [vlt_pkg::AXIS_W-1:0]      best_reg;
    logic                            best_valid_reg;
    logic [vlt_pkg::PROD_W-1:0]      acc1_reg, acc2_reg;
    logic [vlt_pkg::CHUNK_W-1:0]     ch1, ch2;
    logic [vlt_pkg::PP_W-1:0]        pp1, pp2;
    logic [vlt_pkg::NUM_W-1:0]       bn;
    logic [vlt_pkg::DEN_W-1:0]       bd;
    logic                            voxel_valid_reg;
    vlt_pkg::voxel_t                 voxel_reg;

    assign lane_in[0] = seg.start_x;
    assign lane_in[1] = seg.start_y;
    assign lane_in[2] = seg.start_z;
    assign lane_in[3] = seg.end_x;
    assign lane_in[4] = seg.end_y;
    assign lane_in[5] = seg.end_z;

    always_comb
    begin
        for (int l = 0; l < 6; l++)
        begin
            trial[l] = {rem_reg[l], dq_reg[l][CW-1]};
            fit[l]   = trial[l] >= {1'b0, size[l % 3]};
            if (neg_reg[l])
            begin
                fq[l] = (~dq_reg[l] + CW'(1)) - CW'(rem_reg[l] != '0);
                fr[l] = (rem_reg[l] != '0) ? size[l % 3] - rem_reg[l] : '0;
            end
            else
            begin
                fq[l] = dq_reg[l];
                fr[l] = rem_reg[l];
            end
        end
        for (int k = 0; k < 3; k++)
            dlt[k] = {e_reg[k][CW-1], e_reg[k]} - {s_reg[k][CW-1], s_reg[k]};
    end

    assign bn  = num_reg[best_reg];
    assign bd  = den_reg[best_reg];
    assign ch1 = bd[cmd.chunk*vlt_pkg::CHUNK_W +: vlt_pkg::CHUNK_W];
    assign ch2 = den_reg[cmd.axis][cmd.chunk*vlt_pkg::CHUNK_W +: vlt_pkg::CHUNK_W];
    assign pp1 = vlt_pkg::PP_W'(num_reg[cmd.axis]) * vlt_pkg::PP_W'(ch1);
    assign pp2 = vlt_pkg::PP_W'(bn) * vlt_pkg::PP_W'(ch2);

    assign stat.same       = (fq[0] == fq[3]) && (fq[1] == fq[4]) && (fq[2] == fq[5]);
    assign stat.active     = nz_reg[cmd.axis];
    assign stat.best_valid = best_valid_reg;
    assign stat.beyond     = !best_valid_reg || (bn > vlt_pkg::NUM_W'(bd));
    assign stat.less       = acc1_reg < acc2_reg;
    assign stat.out_free   = !voxel_valid_reg || !voxel_stall;

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 6; l++)
        begin
            if (cmd.load)
            begin
                neg_reg[l] <= lane_in[l][CW-1];
                dq_reg[l]  <= lane_in[l][CW-1] ? (~lane_in[l] + CW'(1)) : lane_in[l];
                rem_reg[l] <= '0;
            end
            else if (cmd.div_step)
            begin
                dq_reg[l]  <= {dq_reg[l][CW-2:0], fit[l]};
                rem_reg[l] <= fit[l] ? SW'(trial[l] - {1'b0, size[l % 3]}) : trial[l][SW-1:0];
            end
        end
        if (cmd.load)
        begin
            s_reg[0] <= seg.start_x;
            s_reg[1] <= seg.start_y;
            s_reg[2] <= seg.start_z;
            e_reg[0] <= seg.end_x;
            e_reg[1] <= seg.end_y;
            e_reg[2] <= seg.end_z;
        end
        for (int k = 0; k < 3; k++)
        begin
            if (cmd.init)
            begin
                cur_reg[k]  <= fq[k];
                dneg_reg[k] <= dlt[k][vlt_pkg::DELTA_W-1];
                nz_reg[k]   <= (dlt[k] != '0);
                den_reg[k]  <= dlt[k][vlt_pkg::DELTA_W-1] ?
                               vlt_pkg::DEN_W'(-dlt[k]) : vlt_pkg::DEN_W'(dlt[k]);
                num_reg[k]  <= (!dlt[k][vlt_pkg::DELTA_W-1] && dlt[k] != '0) ?
                               vlt_pkg::NUM_W'(size[k] - fr[k]) : vlt_pkg::NUM_W'(fr[k]);
            end
            else if (cmd.advance && best_reg == vlt_pkg::AXIS_W'(k))
            begin
                cur_reg[k] <= dneg_reg[k] ? cur_reg[k] - CW'(1) : cur_reg[k] + CW'(1);
                num_reg[k] <= num_reg[k] + vlt_pkg::NUM_W'(size[k]);
            end
        end
        if (cmd.mul_clear)
        begin
            acc1_reg <= '0;
            acc2_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            acc1_reg <= acc1_reg + (vlt_pkg::PROD_W'(pp1) << (cmd.chunk*vlt_pkg::CHUNK_W));
            acc2_reg <= acc2_reg + (vlt_pkg::PROD_W'(pp2) << (cmd.chunk*vlt_pkg::CHUNK_W));
        end
        if (cmd.emit)
        begin
            voxel_reg.cell_x    <= cur_reg[0];
            voxel_reg.cell_y    <= cur_reg[1];
            voxel_reg.cell_z    <= cur_reg[2];
            voxel_reg.last_cell <= cmd.last;
            voxel_reg.truncated <= cmd.trunc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg        <= '0;
            best_valid_reg  <= 1'b0;
            voxel_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.best_clear)
                best_valid_reg <= 1'b0;
            else if (cmd.best_take || (cmd.best_upd && stat.less))
            begin
                best_reg       <= cmd.axis;
                best_valid_reg <= 1'b1;
            end
            if (cmd.emit)
                voxel_valid_reg <= 1'b1;
            else if (!voxel_stall)
                voxel_valid_reg <= 1'b0;
        end
    end

    assign voxel_valid = voxel_valid_reg;
    assign voxel       = voxel_reg;

endmodule
